/* hdl/pgcoa_pkg.sv */
package pgcoa_pkg;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_GRAY_EN    = 2'd0,
        REG_GAIN       = 2'd1,
        REG_OFFSET     = 2'd2,
        REG_ALPHA_SCL  = 2'd3
    } reg_idx_t;

    localparam int CFG_DATA_W = 17;

    localparam logic [11:0]        UNITY_GAIN    = 12'd256;
    localparam logic signed [16:0] BYPASS_OFFSET = 17'sd65;
    localparam logic               GRAY_EN_RST   = 1'b0;
    localparam logic signed [16:0] OFFSET_RST    = 17'sd0;
    localparam logic [7:0]         ALPHA_SCL_RST = 8'd255;

    // One RGBA pixel, red in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Register file as seen by the pipeline
    typedef struct packed {
        logic              gray_en;
        logic [11:0]       gain;
        logic signed [16:0] offset;
        logic [7:0]        alpha_scl;
    } cfg_t;

    // Word between the multiply stage and the clamp stage
    typedef struct packed {
        logic signed [20:0] prod_r;
        logic signed [20:0] prod_g;
        logic signed [20:0] prod_b;
        logic [15:0]        alpha_prod;
        logic               bypass;
        pixel_t             pix;
    } mul_word_t;

    // Weighted gray: (11r + 16g + 5b) >> 5
    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [12:0] sum;
        sum = 13'({5'b0, r}) * 13'd11 + {1'b0, g, 4'b0} + 13'({5'b0, b}) * 13'd5;
        return sum[12:5];
    endfunction

    // (c - 128) * gain, fits in 21 signed bits
    function automatic logic signed [20:0] chan_mul(input logic [7:0] c,
                                                    input logic [11:0] gain);
        logic signed [21:0] d;
        logic signed [21:0] gs;
        logic signed [21:0] prod;
        d    = signed'({14'b0, c}) - 22'sd128;
        gs   = signed'({10'b0, gain});
        prod = d * gs;
        return prod[20:0];
    endfunction

    // Add midpoint and offset, scale down by 256, clamp to 0..255
    function automatic logic [7:0] chan_clamp(input logic signed [20:0] prod,
                                              input logic signed [16:0] offset);
        logic signed [22:0] t;
        logic [7:0]         res;
        t = 23'(prod) + 23'sd32768 + 23'(offset);
        if (t[22])
            res = 8'd0;
        else if (|t[21:16])
            res = 8'd255;
        else
            res = t[15:8];
        return res;
    endfunction

    // Exact x / 255 for a 16-bit product
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
        return s[15:8];
    endfunction

endpackage

/* hdl/pgcoa_gray.sv */
module pgcoa_gray (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pgcoa_pkg::pixel_t in_pix,
    input  logic              gray_en,
    output logic              out_valid,
    input  logic              out_ready,
    output pgcoa_pkg::pixel_t out_pix
);

    logic              valid_reg;
    logic              valid_next;
    pgcoa_pkg::pixel_t pix_reg;
    pgcoa_pkg::pixel_t pix_next;
    logic [7:0]        gray;

    // Take a word when empty or when the word held moves on
    assign in_ready = !valid_reg || out_ready;

    assign gray = pgcoa_pkg::gray_of(in_pix.red, in_pix.green, in_pix.blue);

    // When gray_en is set, replace color channels by gray; keep alpha
    always_comb
    begin
        pix_next = in_pix;
        if (gray_en)
        begin
            pix_next.red   = gray;
            pix_next.green = gray;
            pix_next.blue  = gray;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            pix_reg <= pix_next;
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

/* hdl/pgcoa_mul.sv */
module pgcoa_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pgcoa_pkg::pixel_t    in_pix,
    input  pgcoa_pkg::cfg_t      cfg,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pgcoa_pkg::mul_word_t out_word
);

    logic                 valid_reg;
    logic                 valid_next;
    pgcoa_pkg::mul_word_t word_reg;
    pgcoa_pkg::mul_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    // Contrast products, opacity product and the pass-through decision
    always_comb
    begin
        word_next.prod_r     = pgcoa_pkg::chan_mul(in_pix.red, cfg.gain);
        word_next.prod_g     = pgcoa_pkg::chan_mul(in_pix.green, cfg.gain);
        word_next.prod_b     = pgcoa_pkg::chan_mul(in_pix.blue, cfg.gain);
        word_next.alpha_prod = 16'(in_pix.alpha) * 16'(cfg.alpha_scl);
        word_next.bypass     = (cfg.gain == pgcoa_pkg::UNITY_GAIN)
                            && (cfg.offset >= -pgcoa_pkg::BYPASS_OFFSET)
                            && (cfg.offset <= pgcoa_pkg::BYPASS_OFFSET);
        word_next.pix        = in_pix;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* hdl/pgcoa_clamp.sv */
module pgcoa_clamp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pgcoa_pkg::mul_word_t in_word,
    input  logic signed [16:0]   offset,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pgcoa_pkg::pixel_t    out_pix
);

    logic              valid_reg;
    logic              valid_next;
    pgcoa_pkg::pixel_t pix_reg;
    pgcoa_pkg::pixel_t pix_next;

    assign in_ready = !valid_reg || out_ready;

    // Add offset and clamp, or pass colors through; divide alpha by 255
    always_comb
    begin
        if (in_word.bypass)
        begin
            pix_next.red   = in_word.pix.red;
            pix_next.green = in_word.pix.green;
            pix_next.blue  = in_word.pix.blue;
        end
        else
        begin
            pix_next.red   = pgcoa_pkg::chan_clamp(in_word.prod_r, offset);
            pix_next.green = pgcoa_pkg::chan_clamp(in_word.prod_g, offset);
            pix_next.blue  = pgcoa_pkg::chan_clamp(in_word.prod_b, offset);
        end
        pix_next.alpha = pgcoa_pkg::div255(in_word.alpha_prod);
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            pix_reg <= pix_next;
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

/* hdl/pixel_gray_contrast_opacity_adjust_core.sv */
// Pixel adjuster: takes one RGBA pixel per clock and returns it with optional weighted
// gray conversion, contrast and brightness applied to the color channels (clamped to
// 0..255) and alpha scaled by the opacity register. The pipeline has three register
// stages (gray, multiply, clamp and divide by 255), and one pixel per cycle is sustained
// while the output side is ready. Each stage takes a new word whenever it is empty or
// its word moves on, so a stall on the output fills up to three stages before
// s_axis_tready falls. Configuration writes act at once and are meant to be made while
// the pipeline is empty.
module pixel_gray_contrast_opacity_adjust_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
    // Output pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [16:0] cfg_wdata
);

    logic                 gray_en_reg;
    logic [11:0]          gain_reg;
    logic signed [16:0]   offset_reg;
    logic [7:0]           alpha_scl_reg;
    pgcoa_pkg::cfg_t      cfg;

    pgcoa_pkg::pixel_t    in_pix;
    logic                 s1_valid;
    logic                 s1_ready;
    pgcoa_pkg::pixel_t    s1_pix;
    logic                 s2_valid;
    logic                 s2_ready;
    pgcoa_pkg::mul_word_t s2_word;
    pgcoa_pkg::pixel_t    out_pix;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_en_reg   <= pgcoa_pkg::GRAY_EN_RST;
            gain_reg      <= pgcoa_pkg::UNITY_GAIN;
            offset_reg    <= pgcoa_pkg::OFFSET_RST;
            alpha_scl_reg <= pgcoa_pkg::ALPHA_SCL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (pgcoa_pkg::reg_idx_t'(cfg_addr))
                pgcoa_pkg::REG_GRAY_EN:   gray_en_reg   <= cfg_wdata[0];
                pgcoa_pkg::REG_GAIN:      gain_reg      <= cfg_wdata[11:0];
                pgcoa_pkg::REG_OFFSET:    offset_reg    <= signed'(cfg_wdata);
                pgcoa_pkg::REG_ALPHA_SCL: alpha_scl_reg <= cfg_wdata[7:0];
                default:                  gain_reg      <= gain_reg;
            endcase
        end
    end

    assign cfg = '{gray_en:   gray_en_reg,
                   gain:      gain_reg,
                   offset:    offset_reg,
                   alpha_scl: alpha_scl_reg};

    assign in_pix = pgcoa_pkg::pixel_t'(s_axis_tdata);

    pgcoa_gray u_gray (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (in_pix),
        .gray_en   (cfg.gray_en),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_pix   (s1_pix)
    );

    pgcoa_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_pix    (s1_pix),
        .cfg       (cfg),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_word  (s2_word)
    );

    pgcoa_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_word   (s2_word),
        .offset    (cfg.offset),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pix   (out_pix)
    );

    assign m_axis_tdata = 32'(out_pix);

endmodule

/* hdl/pgcoa_checker.sv */
module pgcoa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed or dropped");

    // Keep the output empty once reset has been sampled low
    a_rst_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    // Take input whenever the output is empty or drains
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side free");

    // Deliver an accepted word through the gray, multiply and clamp registers when the output keeps draining
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("accepted word did not reach the output in three cycles");

endmodule

bind pixel_gray_contrast_opacity_adjust_core pgcoa_checker u_pgcoa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
